### src/sorted_insert_priority_queue_assert.svh
// Assertion macros for the sorted insert priority queue.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SIPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// The condition must hold at every clock edge outside reset.
`define SIPQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("invariant check failed");

`endif

### src/sipq_pkg.sv
// Shared types and codes for the sorted insert priority queue.
// Used by sipq_cell and sorted_insert_priority_queue; no dependencies.
package sipq_pkg;

  localparam int unsigned FieldW   = 32;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 80;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

### src/sipq_cell.sv
// One slot of the sorted chain: holds a key and payload and exchanges them
// with its neighbors on insert and remove. Depends on sipq_pkg.
module sipq_cell import sipq_pkg::*; #(
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occ_i,
  input  logic [KEY_WIDTH-1:0]     new_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] new_pay_i,
  input  logic                     left_gt_i,
  input  logic [KEY_WIDTH-1:0]     left_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] left_pay_i,
  input  logic [KEY_WIDTH-1:0]     right_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] right_pay_i,
  output logic                     gt_o,
  output logic [KEY_WIDTH-1:0]     key_o,
  output logic [PAYLOAD_WIDTH-1:0] pay_o
);

  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;

  // An empty slot, or one whose key is strictly larger, yields to the new entry.
  assign gt_o = !occ_i || (new_key_i < key_q);

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    priority if (ctrl_i.rem) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end else begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end
    end else begin
      key_d = key_q;
      pay_d = pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

### src/sorted_insert_priority_queue.sv
// Sorted priority queue built as a chain of DEPTH slots in ascending key order.
// The result of a transaction appears on the master side in the cycle after it
// is accepted. Throughput: one transaction per cycle, limited only by
// m_axis_tready_i through the single output register.
// Reset: rst_ni clears the entry count and the output valid; slot contents are
// not cleared and are read only once written. Depends on sipq_pkg, sipq_cell.
`include "sorted_insert_priority_queue_assert.svh"

module sorted_insert_priority_queue import sipq_pkg::*; #(
  parameter int unsigned DEPTH         = 64,
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: key_in[31:0], payload_in[63:32].
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: action[0].
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0: status[1:0], key_out[33:2], payload_out[65:34],
  // count[72:66], empty_res[73], zero fill[79:74].
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic [OutDataW-1:0]      out_data_q, out_data_d;

  logic                     in_fire;
  action_e                  action;
  logic                     full, empty;
  cell_ctrl_t               ctrl;
  logic [63:0]              key_wide, pay_wide, head_key_wide, head_pay_wide;
  logic [KEY_WIDTH-1:0]     new_key;
  logic [PAYLOAD_WIDTH-1:0] new_pay;
  logic [DEPTH-1:0]         occ, gt;
  logic [KEY_WIDTH-1:0]     keys [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pays [DEPTH];
  status_e                  status;
  logic [FieldW-1:0]        key_out, pay_out;
  logic [31:0]              count_ext;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign action  = action_e'(s_axis_tuser_i);
  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);

  assign key_wide = 64'(s_axis_tdata_i[FieldW-1:0]);
  assign pay_wide = 64'(s_axis_tdata_i[InDataW-1:FieldW]);
  assign new_key  = key_wide[KEY_WIDTH-1:0];
  assign new_pay  = pay_wide[PAYLOAD_WIDTH-1:0];

  assign ctrl.ins = in_fire && (action == ACT_INSERT) && !full;
  assign ctrl.rem = in_fire && (action == ACT_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_gt;
    logic [KEY_WIDTH-1:0]     left_key, right_key;
    logic [PAYLOAD_WIDTH-1:0] left_pay, right_pay;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_key = new_key;
      assign left_pay = new_pay;
    end else begin : g_mid
      assign left_gt  = gt[i-1];
      assign left_key = keys[i-1];
      assign left_pay = pays[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = keys[i];
      assign right_pay = pays[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
      assign right_pay = pays[i+1];
    end

    sipq_cell #(
      .KEY_WIDTH    (KEY_WIDTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .new_key_i  (new_key),
      .new_pay_i  (new_pay),
      .left_gt_i  (left_gt),
      .left_key_i (left_key),
      .left_pay_i (left_pay),
      .right_key_i(right_key),
      .right_pay_i(right_pay),
      .gt_o       (gt[i]),
      .key_o      (keys[i]),
      .pay_o      (pays[i])
    );
  end

  assign head_key_wide = 64'(keys[0]);
  assign head_pay_wide = 64'(pays[0]);

  always_comb begin
    count_d = count_q;
    status  = ST_OK;
    key_out = '0;
    pay_out = '0;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end
    if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
      key_out = head_key_wide[FieldW-1:0];
      pay_out = head_pay_wide[FieldW-1:0];
    end
    if (action == ACT_INSERT && full) begin
      status = ST_FULL;
    end
    if (action == ACT_REMOVE && empty) begin
      status = ST_EMPTY;
    end
  end

  assign count_ext = 32'(count_d);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'd0, (count_d == '0), count_ext[CountOutW-1:0], pay_out, key_out,
                     status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `SIPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(DEPTH))
  `SIPQ_ASSERT_NEXT(a_result_follows, in_fire, out_valid_q)
  `SIPQ_ASSERT_NEXT(a_empty_remove, in_fire && action == ACT_REMOVE && empty, out_data_q[1:0] == ST_EMPTY && count_q == '0)
  `SIPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_q == $past(count_q) + CntW'(1))

endmodule

### tb/sorted_insert_priority_queue_tb.sv
// Self-checking testbench for sorted_insert_priority_queue: it drives insert and remove
// transactions with random stalls and checks every result against a behavioral queue.
// Depends on sipq_pkg and the sorted_insert_priority_queue RTL.
module sorted_insert_priority_queue_tb;
  import sipq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 64;
  localparam int RANDOM_ITEMS = 550;

  class pq_scoreboard;
    typedef struct {
      status_e              status;
      logic [FieldW-1:0]    key;
      logic [FieldW-1:0]    payload;
      logic [CountOutW-1:0] count;
      logic                 empty;
    } outcome_t;

    logic [FieldW-1:0] held_keys[$];
    logic [FieldW-1:0] held_payloads[$];
    outcome_t expected_outcomes[$];
    int failures;
    int checked;
    int inserts;
    int removes;
    int empty_removes;
    int full_drops;
    int peak_fill;

    function new();
      failures = 0;
      checked = 0;
      inserts = 0;
      removes = 0;
      empty_removes = 0;
      full_drops = 0;
      peak_fill = 0;
    endfunction

    function void note_request(action_e action, logic [FieldW-1:0] key,
                               logic [FieldW-1:0] payload);
      outcome_t outcome;
      int slot;
      outcome.status = ST_OK;
      outcome.key = '0;
      outcome.payload = '0;
      if (action == ACT_INSERT) begin
        inserts++;
        if (held_keys.size() >= QDEPTH) begin
          outcome.status = ST_FULL;
          full_drops++;
        end else begin
          slot = held_keys.size();
          while (slot > 0 && key < held_keys[slot-1]) slot--;
          held_keys.insert(slot, key);
          held_payloads.insert(slot, payload);
        end
      end else begin
        removes++;
        if (held_keys.size() == 0) begin
          outcome.status = ST_EMPTY;
          empty_removes++;
        end else begin
          outcome.key = held_keys.pop_front();
          outcome.payload = held_payloads.pop_front();
        end
      end
      outcome.count = CountOutW'(held_keys.size());
      outcome.empty = (held_keys.size() == 0);
      if (held_keys.size() > peak_fill) peak_fill = held_keys.size();
      expected_outcomes.push_back(outcome);
    endfunction

    function void compare_field(string name, logic [FieldW-1:0] want, logic [FieldW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_response(logic [OutDataW-1:0] data);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with nothing pending: %h", data);
        failures++;
        return;
      end
      want = expected_outcomes.pop_front();
      checked++;
      compare_field("status", FieldW'(want.status), FieldW'(data[1:0]));
      compare_field("key_out", want.key, data[33:2]);
      compare_field("payload_out", want.payload, data[65:34]);
      compare_field("count", FieldW'(want.count), FieldW'(data[72:66]));
      compare_field("empty_res", FieldW'(want.empty), FieldW'(data[73]));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_valid;
  logic [InDataW-1:0] s_tdata;
  action_e s_action;
  logic m_ready;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  bit no_idle;
  pq_scoreboard sb;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_insert_priority_queue #(
    .DEPTH(QDEPTH),
    .KEY_WIDTH(32),
    .PAYLOAD_WIDTH(32)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_action),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        sb.note_request(s_action, s_tdata[31:0], s_tdata[63:32]);
      end
      if (m_axis_tvalid_o && m_ready) begin
        sb.check_response(m_axis_tdata_o);
      end
    end
  end

  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_ready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic send_request(action_e action, logic [FieldW-1:0] key,
                              logic [FieldW-1:0] payload);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_action = action;
    s_tdata = {payload, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [FieldW-1:0] pick_key(int mode);
    logic [FieldW-1:0] corners[4];
    corners = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 15);
      default: begin
        if ($urandom_range(0, 1) == 0) return corners[$urandom_range(0, 3)];
        return $urandom;
      end
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int span;
    int key_mode;
    int insert_pct;
    sb = new();
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_action = ACT_INSERT;
    s_tdata = '0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'h0, 32'h0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'd5, 32'hA);
    send_request(ACT_INSERT, 32'd5, 32'hB);
    send_request(ACT_INSERT, 32'd5, 32'hC);
    send_request(ACT_INSERT, 32'd3, 32'h5555_5555);
    send_request(ACT_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
    repeat (7) send_request(ACT_REMOVE, $urandom, $urandom);
    send_request(ACT_REMOVE, 32'h0, 32'h0);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h1);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h2);
    send_request(ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
    repeat (3) send_request(ACT_REMOVE, $urandom, $urandom);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      span = $urandom_range(80, 110);
      key_mode = $urandom_range(0, 2);
      case (phase % 3)
        0: insert_pct = 90;
        1: insert_pct = 10;
        default: insert_pct = 50;
      endcase
      no_idle = (phase == 3);
      for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          send_request(ACT_INSERT, pick_key(key_mode), $urandom);
        end else begin
          send_request(ACT_REMOVE, $urandom, $urandom);
        end
        sent++;
      end
      phase++;
    end
    s_valid = 1'b0;
    no_idle = 1'b0;

    while (sb.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped on a full queue) and %0d removes (%0d on empty).",
             sb.inserts, sb.full_drops, sb.removes, sb.empty_removes);
    $display("Checked %0d results; the queue peaked at %0d of %0d entries.",
             sb.checked, sb.peak_fill, QDEPTH);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
